/* sv/rtnp_pkg.sv */
// shared types, register indexes and the product sequence table for the ray/triangle pick
`timescale 1ns / 1ps
package rtnp_pkg;

	localparam int DIGIT_W = 8;
	localparam int N_UOPS = 24;
	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_ACCUM,
		ST_FOLD,
		ST_CHECK,
		ST_DIV_WAIT,
		ST_UPDATE
	} state_t;

	typedef enum logic [1:0] {A_E2, A_E1, A_P, A_Q} a_sel_t;
	typedef enum logic [1:0] {B_D, B_E1, B_S, B_E2} b_sel_t;
	typedef enum logic [2:0] {D_P, D_Q, D_DET, D_UN, D_VN, D_TN} dst_t;

	typedef struct packed {
		a_sel_t     a_sel;
		logic [1:0] a_idx;
		b_sel_t     b_sel;
		logic [1:0] b_idx;
		logic       sub;
		logic       first;
		logic       last;
		dst_t       dst;
		logic [1:0] dst_idx;
	} uop_t;

	function automatic uop_t rtnp_uop(input logic [STEP_W-1:0] step);
		uop_t r;
		case (step)
			5'd0: r = '{A_E2, 2'd2, B_D, 2'd1, 1'b0, 1'b1, 1'b0, D_P, 2'd0};
			5'd1: r = '{A_E2, 2'd1, B_D, 2'd2, 1'b1, 1'b0, 1'b1, D_P, 2'd0};
			5'd2: r = '{A_E2, 2'd0, B_D, 2'd2, 1'b0, 1'b1, 1'b0, D_P, 2'd1};
			5'd3: r = '{A_E2, 2'd2, B_D, 2'd0, 1'b1, 1'b0, 1'b1, D_P, 2'd1};
			5'd4: r = '{A_E2, 2'd1, B_D, 2'd0, 1'b0, 1'b1, 1'b0, D_P, 2'd2};
			5'd5: r = '{A_E2, 2'd0, B_D, 2'd1, 1'b1, 1'b0, 1'b1, D_P, 2'd2};
			5'd6: r = '{A_P, 2'd0, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_DET, 2'd0};
			5'd7: r = '{A_P, 2'd1, B_E1, 2'd1, 1'b0, 1'b0, 1'b0, D_DET, 2'd0};
			5'd8: r = '{A_P, 2'd2, B_E1, 2'd2, 1'b0, 1'b0, 1'b1, D_DET, 2'd0};
			5'd9: r = '{A_P, 2'd0, B_S, 2'd0, 1'b0, 1'b1, 1'b0, D_UN, 2'd0};
			5'd10: r = '{A_P, 2'd1, B_S, 2'd1, 1'b0, 1'b0, 1'b0, D_UN, 2'd0};
			5'd11: r = '{A_P, 2'd2, B_S, 2'd2, 1'b0, 1'b0, 1'b1, D_UN, 2'd0};
			5'd12: r = '{A_E1, 2'd2, B_S, 2'd1, 1'b0, 1'b1, 1'b0, D_Q, 2'd0};
			5'd13: r = '{A_E1, 2'd1, B_S, 2'd2, 1'b1, 1'b0, 1'b1, D_Q, 2'd0};
			5'd14: r = '{A_E1, 2'd0, B_S, 2'd2, 1'b0, 1'b1, 1'b0, D_Q, 2'd1};
			5'd15: r = '{A_E1, 2'd2, B_S, 2'd0, 1'b1, 1'b0, 1'b1, D_Q, 2'd1};
			5'd16: r = '{A_E1, 2'd1, B_S, 2'd0, 1'b0, 1'b1, 1'b0, D_Q, 2'd2};
			5'd17: r = '{A_E1, 2'd0, B_S, 2'd1, 1'b1, 1'b0, 1'b1, D_Q, 2'd2};
			5'd18: r = '{A_Q, 2'd0, B_D, 2'd0, 1'b0, 1'b1, 1'b0, D_VN, 2'd0};
			5'd19: r = '{A_Q, 2'd1, B_D, 2'd1, 1'b0, 1'b0, 1'b0, D_VN, 2'd0};
			5'd20: r = '{A_Q, 2'd2, B_D, 2'd2, 1'b0, 1'b0, 1'b1, D_VN, 2'd0};
			5'd21: r = '{A_Q, 2'd0, B_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_TN, 2'd0};
			5'd22: r = '{A_Q, 2'd1, B_E2, 2'd1, 1'b0, 1'b0, 1'b0, D_TN, 2'd0};
			5'd23: r = '{A_Q, 2'd2, B_E2, 2'd2, 1'b0, 1'b0, 1'b1, D_TN, 2'd0};
			default: r = '{A_E2, 2'd0, B_D, 2'd0, 1'b0, 1'b0, 1'b0, D_P, 2'd0};
		endcase
		return r;
	endfunction

endpackage

/* sv/rtnp_mul.sv */
// shared signed multiplier, one byte of the narrow operand per cycle
`timescale 1ns / 1ps
module rtnp_mul
	import rtnp_pkg::*;
#(
	parameter int MA_W = 67,
	parameter int MB_W = 33
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic                   done,
	output logic [MA_W+MB_W-1:0]   mag,
	output logic                   neg
);

	localparam int P_W = MA_W + MB_W;
	localparam int NDIG = (MB_W + DIGIT_W - 1) / DIGIT_W;
	localparam int BPAD = NDIG * DIGIT_W;
	localparam int CNT_W = $clog2(NDIG + 1);

	logic [MA_W-1:0]        amag_q;
	logic [BPAD-1:0]        bsh_q;
	logic [P_W-1:0]         prod_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [MB_W-1:0]        bmag;
	logic [MA_W+DIGIT_W-1:0] pp;

	assign bmag = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
	assign pp = (MA_W + DIGIT_W)'(amag_q) * (MA_W + DIGIT_W)'(bsh_q[BPAD-1 -: DIGIT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(NDIG);
			run_q <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amag_q <= a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
			bsh_q <= BPAD'(bmag);
			prod_q <= '0;
			neg_q <= a[MA_W-1] ^ b[MB_W-1];
		end else if (run_q) begin
			prod_q <= {prod_q[P_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + P_W'(pp);
			bsh_q <= bsh_q << DIGIT_W;
		end
	end

	assign done = done_q;
	assign mag = prod_q;
	assign neg = neg_q;

endmodule

/* sv/rtnp_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rtnp_div
	import rtnp_pkg::*;
#(
	parameter int ACC_W = 150,
	parameter int Q_W = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic                    done,
	output logic [Q_W-1:0]          quo
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] dv_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ge;

	assign ge = rem_q >= dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
			run_q <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ACC_W'(num);
			dv_q <= ACC_W'(den) << (Q_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			quo_q <= {quo_q[Q_W-2:0], ge};
			dv_q <= dv_q >> 1;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

/* sv/ray_triangle_nearest_pick.sv */
// top level: nearest ray/triangle hit over a stream of triangles
//
// configuration: cfg_we writes register cfg_index (origin x/y/z, direction x/y/z)
// with cfg_wdata; write only while the block is idle.
// input stream s_*: one triangle per transfer, s_tlast marks the last triangle
// of the scene. output stream m_*: one result per scene, sent after the last
// triangle; m_tuser is the hit flag.
// each triangle runs 24 products through one shared multiplier, then, when the
// hit test passes, a restoring divide that yields a COORD_BITS-1 bit distance.
// s_tready is high only between triangles.
// the result goes to an output register, so the next scene can start while it
// waits; if the result register is still full when the next last triangle
// finishes, the block holds until m_tready takes the old result.
// reset clears the running best, the output valid flag and the ray registers
// (direction defaults to +z).
`timescale 1ns / 1ps
module ray_triangle_nearest_pick
	import rtnp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	parameter int FACE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [((COORD_BITS > FRAC_BITS + 2) ? COORD_BITS : FRAC_BITS + 2)-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z, tri_object, tri_face
	input  logic [((9 * COORD_BITS + 32 + FACE_BITS + 7) / 8) * 8-1:0] s_tdata,
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// hit_object, hit_face, hit_distance
	output logic [((32 + FACE_BITS + COORD_BITS - 1 + 7) / 8) * 8-1:0] m_tdata,
	// hit
	output logic                      m_tuser
);

	localparam int CB = COORD_BITS;
	localparam int DB = FRAC_BITS + 2;
	localparam int DIST_W = CB - 1;
	localparam int MB_W = (CB + 1 > DB) ? CB + 1 : DB;
	localparam int MA_W = (2 * CB + 3 > DB + CB + 2) ? 2 * CB + 3 : DB + CB + 2;
	localparam int P_W = MA_W + MB_W;
	localparam int ACC_W = P_W + 2 + FRAC_BITS + CB;
	localparam int OUT_W = 32 + FACE_BITS + DIST_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	state_t state_q, state_nx;

	logic signed [CB-1:0]    org_q [3];
	logic signed [DB-1:0]    dir_q [3];
	logic signed [CB-1:0]    vin [9];
	logic signed [CB:0]      e1_q [3];
	logic signed [CB:0]      e2_q [3];
	logic signed [CB:0]      s_q [3];
	logic signed [MA_W-1:0]  p_q [3];
	logic signed [MA_W-1:0]  q_q [3];
	logic signed [ACC_W-1:0] acc_q, det_q, un_q, vn_q, tn_q;
	logic [31:0]             obj_q;
	logic [FACE_BITS-1:0]    face_q;
	logic                    last_q;
	logic [STEP_W-1:0]       step_q;
	logic                    hit_q;
	logic [DIST_W-1:0]       dist_q;

	logic                    best_valid_q;
	logic [CB-1:0]           best_dist_q;
	logic [31:0]             best_obj_q;
	logic [FACE_BITS-1:0]    best_face_q;

	logic                    out_valid_q;
	logic                    out_hit_q;
	logic [OUT_W-1:0]        out_data_q;

	uop_t                    u;
	logic signed [MA_W-1:0]  a_op;
	logic signed [MB_W-1:0]  b_op;
	logic                    mul_start, mul_done, mul_neg;
	logic [P_W-1:0]          mul_mag;
	logic signed [ACC_W-1:0] term, base, acc_nx;
	logic                    div_start, div_done;
	logic [DIST_W-1:0]       div_quo;
	logic signed [ACC_W-1:0] thr, ad_sh;
	logic                    ok, sat, fneg;
	logic                    in_acc, out_free, emit, upd, better;
	logic                    nb_valid;
	logic [CB-1:0]           nb_dist;
	logic [31:0]             nb_obj;
	logic [FACE_BITS-1:0]    nb_face;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			vin[i] = s_tdata[i*CB +: CB];
		end
	end

	assign u = rtnp_uop(step_q);

	always_comb begin
		case (u.a_sel)
			A_E2: a_op = MA_W'(e2_q[u.a_idx]);
			A_E1: a_op = MA_W'(e1_q[u.a_idx]);
			A_P: a_op = p_q[u.a_idx];
			A_Q: a_op = q_q[u.a_idx];
			default: a_op = '0;
		endcase
		case (u.b_sel)
			B_D: b_op = MB_W'(dir_q[u.b_idx]);
			B_E1: b_op = MB_W'(e1_q[u.b_idx]);
			B_S: b_op = MB_W'(s_q[u.b_idx]);
			B_E2: b_op = MB_W'(e2_q[u.b_idx]);
			default: b_op = '0;
		endcase
	end

	rtnp_mul #(.MA_W(MA_W), .MB_W(MB_W)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(a_op),
		.b(b_op),
		.done(mul_done),
		.mag(mul_mag),
		.neg(mul_neg)
	);

	rtnp_div #(.ACC_W(ACC_W), .Q_W(DIST_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(tn_q),
		.den(det_q),
		.done(div_done),
		.quo(div_quo)
	);

	assign term = ACC_W'(mul_mag);
	assign base = u.first ? '0 : acc_q;
	assign acc_nx = (mul_neg ^ u.sub) ? base - term : base + term;

	assign thr = ACC_W'(1) << (2 * FRAC_BITS);
	assign ad_sh = det_q <<< DIST_W;
	assign fneg = det_q[ACC_W-1];
	assign ok = (det_q >= thr) && !un_q[ACC_W-1] && (det_q >= un_q) && !vn_q[ACC_W-1]
		&& (det_q >= un_q + vn_q) && (tn_q > det_q);
	assign sat = tn_q >= ad_sh;

	assign in_acc = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign better = hit_q && (!best_valid_q || CB'(dist_q) < best_dist_q);

	always_comb begin
		if (better) begin
			nb_valid = 1'b1;
			nb_dist = CB'(dist_q);
			nb_obj = obj_q;
			nb_face = face_q;
		end else begin
			nb_valid = best_valid_q;
			nb_dist = best_dist_q;
			nb_obj = best_obj_q;
			nb_face = best_face_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_nx = ST_MUL_GO;
			ST_MUL_GO: state_nx = ST_MUL_WAIT;
			ST_MUL_WAIT: if (mul_done) state_nx = ST_ACCUM;
			ST_ACCUM: begin
				if (step_q == STEP_W'(N_UOPS - 1)) state_nx = ST_FOLD;
				else state_nx = ST_MUL_GO;
			end
			ST_FOLD: state_nx = ST_CHECK;
			ST_CHECK: begin
				if (ok && !sat) state_nx = ST_DIV_WAIT;
				else state_nx = ST_UPDATE;
			end
			ST_DIV_WAIT: if (div_done) state_nx = ST_UPDATE;
			ST_UPDATE: if (!last_q || out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		emit = 1'b0;
		upd = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL_GO: mul_start = 1'b1;
			ST_CHECK: div_start = ok && !sat;
			ST_UPDATE: begin
				emit = last_q && out_free;
				upd = !last_q || out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_ACCUM) begin
				step_q <= (step_q == STEP_W'(N_UOPS - 1)) ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
			end
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DB'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: org_q[0] <= cfg_wdata[CB-1:0];
				REG_ORIGIN_Y: org_q[1] <= cfg_wdata[CB-1:0];
				REG_ORIGIN_Z: org_q[2] <= cfg_wdata[CB-1:0];
				REG_DIR_X: dir_q[0] <= cfg_wdata[DB-1:0];
				REG_DIR_Y: dir_q[1] <= cfg_wdata[DB-1:0];
				REG_DIR_Z: dir_q[2] <= cfg_wdata[DB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= (CB + 1)'(vin[3+i]) - (CB + 1)'(vin[i]);
				e2_q[i] <= (CB + 1)'(vin[6+i]) - (CB + 1)'(vin[i]);
				s_q[i] <= (CB + 1)'(org_q[i]) - (CB + 1)'(vin[i]);
			end
			obj_q <= s_tdata[9*CB +: 32];
			face_q <= s_tdata[9*CB+32 +: FACE_BITS];
			last_q <= s_tlast;
		end
		if (state_q == ST_ACCUM) begin
			acc_q <= acc_nx;
			if (u.last) begin
				case (u.dst)
					D_P: p_q[u.dst_idx] <= MA_W'(acc_nx);
					D_Q: q_q[u.dst_idx] <= MA_W'(acc_nx);
					D_DET: det_q <= acc_nx;
					D_UN: un_q <= acc_nx;
					D_VN: vn_q <= acc_nx;
					D_TN: tn_q <= acc_nx;
					default: ;
				endcase
			end
		end
		if (state_q == ST_FOLD) begin
			det_q <= fneg ? -det_q : det_q;
			un_q <= fneg ? -un_q : un_q;
			vn_q <= fneg ? -vn_q : vn_q;
			tn_q <= (fneg ? -tn_q : tn_q) <<< FRAC_BITS;
		end
		if (state_q == ST_CHECK) begin
			hit_q <= ok;
			dist_q <= '1;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			dist_q <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_dist_q <= '1;
			best_obj_q <= '0;
			best_face_q <= '0;
		end else if (emit) begin
			best_valid_q <= 1'b0;
			best_dist_q <= '1;
			best_obj_q <= '0;
			best_face_q <= '0;
		end else if (upd) begin
			best_valid_q <= nb_valid;
			best_dist_q <= nb_dist;
			best_obj_q <= nb_obj;
			best_face_q <= nb_face;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_hit_q <= nb_valid;
			out_data_q <= nb_valid ? {nb_dist[DIST_W-1:0], nb_face, nb_obj} : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_hit_q;
	assign m_tdata = OUT_TW'(out_data_q);

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready while a triangle is in flight");

	a_step_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |-> (step_q == '0))
		else $error("product sequence did not wrap after the last step");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (m_tvalid && !best_valid_q))
		else $error("result not presented or best not cleared after last triangle");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && last_q && m_tvalid && !m_tready) |-> !emit)
		else $error("result register overwritten while full");

endmodule
